// File: rtl/core/m4i_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_pkg: shared types and helpers for the 4x4 matrix inverse
// Term sequencing table, saturating 64-bit arithmetic and the control and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package m4i_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int N_COF      = 36;
  localparam int N_TRI      = 48;
  localparam int N_DET      = 4;
  localparam int N_TERMS    = N_COF + N_TRI + N_DET;
  localparam int ADJ_BASE   = 18;
  localparam int WORK_DEPTH = 34;
  localparam int WORK_AW    = $clog2(WORK_DEPTH);
  localparam int MAT_WIDTH  = 128;
  localparam int MAT_DEPTH  = 4;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    MODE_FIRST,
    MODE_ADD,
    MODE_SUB
  } comb_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_CAPB,
    ST_MUL,
    ST_MWAIT,
    ST_WR,
    ST_DRD,
    ST_DCAP,
    ST_DSTART,
    ST_DWAIT,
    ST_OUT
  } m4i_state_t;

  typedef struct packed {
    logic               work;
    logic [WORK_AW-1:0] addr;
  } opnd_t;

  typedef struct packed {
    opnd_t              opa;
    opnd_t              opb;
    comb_mode_t         mode;
    logic               save_hold;
    logic               wr;
    logic               neg;
    logic               merge;
    logic               to_det;
    logic [WORK_AW-1:0] dst;
  } term_t;

  typedef struct packed {
    opnd_t              rd_op;
    logic               cap_a;
    logic               cap_b;
    logic               mul_start;
    comb_mode_t         mode;
    logic               save_hold;
    logic               wr_en;
    logic               wr_neg;
    logic               wr_merge;
    logic               wr_det;
    logic [WORK_AW-1:0] wr_addr;
    logic               div_start;
    logic               zero_st;
    logic [1:0]         row;
  } m4i_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic singular;
  } m4i_sts_t;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_neg(input logic [63:0] a);
    return (a == S64_MIN) ? S64_MAX : (64'd0 - a);
  endfunction

  // floor(x/3) for x < 64
  function automatic logic [5:0] div3(input logic [5:0] x);
    logic [12:0] p;
    p = 13'(x) * 13'd43;
    return p[12:7];
  endfunction

  function automatic opnd_t mat_op(input logic [1:0] c, input logic [1:0] r);
    opnd_t o;
    o.work = 1'b0;
    o.addr = {2'b00, c, r};
    return o;
  endfunction

  function automatic opnd_t work_op(input logic [WORK_AW-1:0] a);
    opnd_t o;
    o.work = 1'b1;
    o.addr = a;
    return o;
  endfunction

  // Product sequence: cofactor pairs, adjugate triples, determinant
  function automatic term_t term_of(input logic [6:0] t);
    term_t      tm;
    logic [5:0] k;
    logic [5:0] p;
    logic [5:0] u;
    logic [5:0] e6;
    logic [1:0] j;
    logic [1:0] s;
    logic [1:0] c;
    logic [1:0] ra;
    logic [1:0] rb;
    logic [1:0] ca;
    logic [1:0] cb;
    logic [1:0] v;
    logic [2:0] f;
    logic [1:0] d;
    tm = '0;
    if (t < 7'(N_COF)) begin
      k = t[6:1];
      p = div3(k);
      j = 2'(k - (p + p + p));
      case (p)
        6'd0: begin ra = 2'd2; rb = 2'd3; end
        6'd1: begin ra = 2'd1; rb = 2'd3; end
        6'd2: begin ra = 2'd1; rb = 2'd2; end
        6'd3: begin ra = 2'd0; rb = 2'd3; end
        6'd4: begin ra = 2'd0; rb = 2'd2; end
        default: begin ra = 2'd0; rb = 2'd1; end
      endcase
      case (j)
        2'd0: begin ca = 2'd2; cb = 2'd3; end
        2'd1: begin ca = 2'd1; cb = 2'd3; end
        default: begin ca = 2'd1; cb = 2'd2; end
      endcase
      if (!t[0]) begin
        tm.opa  = mat_op(ca, ra);
        tm.opb  = mat_op(cb, rb);
        tm.mode = MODE_FIRST;
      end else begin
        tm.opa  = mat_op(cb, ra);
        tm.opb  = mat_op(ca, rb);
        tm.mode = MODE_SUB;
        tm.wr   = 1'b1;
        tm.dst  = WORK_AW'(k);
      end
    end else if (t < 7'(N_COF + N_TRI)) begin
      u  = 6'(t - 7'(N_COF));
      e6 = div3(u);
      s  = 2'(u - (e6 + e6 + e6));
      c  = e6[3:2];
      j  = e6[1:0];
      v  = (s >= c) ? s + 2'd1 : s;
      case ({c, s})
        4'h0: f = 3'd0;
        4'h1: f = 3'd1;
        4'h2: f = 3'd2;
        4'h4: f = 3'd0;
        4'h5: f = 3'd3;
        4'h6: f = 3'd4;
        4'h8: f = 3'd1;
        4'h9: f = 3'd3;
        4'hA: f = 3'd5;
        4'hC: f = 3'd2;
        4'hD: f = 3'd4;
        default: f = 3'd5;
      endcase
      tm.opa = (j == 2'd0) ? mat_op(2'd1, v) : mat_op(2'd0, v);
      tm.opb = work_op(WORK_AW'(6'({3'b000, f} * 6'd3) +
                                6'((j == 2'd0) ? 2'd0 : j - 2'd1)));
      case (s)
        2'd0: tm.mode = MODE_FIRST;
        2'd1: tm.mode = MODE_SUB;
        default: begin
          tm.mode = MODE_ADD;
          tm.wr   = 1'b1;
          tm.dst  = WORK_AW'(6'(ADJ_BASE) + {2'b00, e6[3:0]});
          tm.neg  = c[0] ^ j[0];
        end
      endcase
    end else begin
      d      = t[1:0];
      tm.opa = work_op(WORK_AW'(6'(ADJ_BASE) + {2'b00, d, 2'b00}));
      tm.opb = mat_op(2'd0, d);
      case (d)
        2'd0: tm.mode = MODE_FIRST;
        2'd1: begin
          tm.mode      = MODE_ADD;
          tm.save_hold = 1'b1;
        end
        2'd2: tm.mode = MODE_FIRST;
        default: begin
          tm.mode   = MODE_ADD;
          tm.wr     = 1'b1;
          tm.merge  = 1'b1;
          tm.to_det = 1'b1;
        end
      endcase
    end
    return tm;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/m4i_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_if: request channels of the 4x4 matrix inverse
// Column load channel and inverse column result channel, valid/ready.
// ----------------------------------------------------------------------------
interface m4i_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         col_sel;
  logic signed [31:0] val_r0;
  logic signed [31:0] val_r1;
  logic signed [31:0] val_r2;
  logic signed [31:0] val_r3;
  logic               is_last;

  modport source(output valid, col_sel, val_r0, val_r1, val_r2, val_r3, is_last,
                 input ready);
  modport sink(input valid, col_sel, val_r0, val_r1, val_r2, val_r3, is_last,
               output ready);
endinterface

interface m4i_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         out_col;
  logic signed [31:0] inv_r0;
  logic signed [31:0] inv_r1;
  logic signed [31:0] inv_r2;
  logic signed [31:0] inv_r3;
  logic               singular;
  logic               end_of_run;

  modport source(output valid, out_col, inv_r0, inv_r1, inv_r2, inv_r3, singular,
                 end_of_run, input ready);
  modport sink(input valid, out_col, inv_r0, inv_r1, inv_r2, inv_r3, singular,
               end_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/core/m4i_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module m4i_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/core/m4i_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_mul: sequential fixed-point multiplier
// 64x64 signed product from four 32x32 partial products, floor-scaled by
// 2^FRAC_BITS and saturated to 64 bits. The product and done are registered
// together when the last phase ends.
// ----------------------------------------------------------------------------
module m4i_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  localparam logic [127:0] RND = (128'd1 << FRAC_BITS) - 128'd1;
  localparam logic [63:0] S64_MAX_L = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN_L = 64'h8000_0000_0000_0000;

  logic         busy_r, busy_nxt;
  logic [2:0]   ph_r, ph_nxt;
  logic         done_r, done_nxt;
  logic         neg_r;
  logic [63:0]  ma_r, mb_r;
  logic [63:0]  pp_r;
  logic [127:0] acc_r;
  logic [63:0]  prod_r;
  logic [31:0]  a_part, b_part;
  logic [6:0]   shamt;
  logic [63:0]  q, lim, qs;
  logic         hi_nz;

  assign a_part = ph_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign b_part = ph_r[0] ? mb_r[63:32] : mb_r[31:0];

  always_comb begin
    case (ph_r)
      3'd1:    shamt = 7'd0;
      3'd4:    shamt = 7'd64;
      default: shamt = 7'd32;
    endcase
  end

  assign q     = acc_r[FRAC_BITS +: 64];
  assign hi_nz = (acc_r >> (64 + FRAC_BITS)) != 128'd0;
  assign lim   = neg_r ? S64_MIN_L : S64_MAX_L;
  assign qs    = (hi_nz || (q > lim)) ? lim : q;

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      ph_nxt   = 3'd0;
    end else if (busy_r) begin
      ph_nxt = ph_r + 3'd1;
      if (ph_r == 3'd6) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 3'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= a[63] ^ b[63];
      ma_r  <= a[63] ? 64'd0 - a : a;
      mb_r  <= b[63] ? 64'd0 - b : b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (ph_r <= 3'd3) begin
        pp_r <= 64'(a_part * b_part);
      end
      if (ph_r >= 3'd1 && ph_r <= 3'd4) begin
        acc_r <= acc_r + ({64'd0, pp_r} << shamt);
      end
      if (ph_r == 3'd5 && neg_r) begin
        acc_r <= acc_r + RND;
      end
      if (ph_r == 3'd6) begin
        prod_r <= neg_r ? 64'd0 - qs : qs;
      end
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule
`default_nettype wire

// File: rtl/core/m4i_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_div: bit-serial fixed-point divider
// trunc(num * 2^FRAC_BITS / den), restoring, one quotient bit per cycle,
// saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
module m4i_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [31:0] quo
);

  localparam int DVD_W = 64 + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DVD_W-1:0] dvd_r;
  logic [63:0]      rem_r;
  logic [63:0]      den_r;
  logic [32:0]      q_r;
  logic             ovf_r;
  logic             neg_r;
  logic [31:0]      quo_r;
  logic [64:0]      rs;
  logic [64:0]      diff;
  logic             ge;
  logic [32:0]      lim, qs;

  assign rs   = {rem_r, dvd_r[DVD_W-1]};
  assign diff = rs - {1'b0, den_r};
  assign ge   = rs >= {1'b0, den_r};
  assign lim  = neg_r ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
  assign qs   = (ovf_r || (q_r > lim)) ? lim : q_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[63] ^ den[63];
      dvd_r <= {(num[63] ? 64'd0 - num : num), {FRAC_BITS{1'b0}}};
      den_r <= den[63] ? 64'd0 - den : den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_r <= ge ? diff[63:0] : rs[63:0];
        q_r   <= {q_r[31:0], ge};
        ovf_r <= ovf_r | q_r[32];
        dvd_r <= dvd_r << 1;
      end else begin
        quo_r <= neg_r ? 32'd0 - qs[31:0] : qs[31:0];
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// File: rtl/core/m4i_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_dp: datapath of the 4x4 matrix inverse
// Matrix and work stores, operand registers, shared multiplier with
// saturating accumulator, divider and the result column buffer.
// ----------------------------------------------------------------------------
module m4i_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  logic [1:0]                col_sel,
  input  logic [31:0]               val_r0,
  input  logic [31:0]               val_r1,
  input  logic [31:0]               val_r2,
  input  logic [31:0]               val_r3,
  input  m4i_pkg::m4i_cmd_t         cmd,
  output m4i_pkg::m4i_sts_t         sts,
  output logic [3:0][31:0]          rslt
);
  import m4i_pkg::*;

  logic [MAT_WIDTH-1:0] mat_rdata;
  logic [63:0]          work_rdata;
  logic                 rd_work_r;
  logic [1:0]           rd_row_r;
  logic [31:0]          mat_elem;
  logic [63:0]          opnd_val;
  logic [63:0]          opa_r, opb_r;
  logic [63:0]          acc_r, acc_nxt;
  logic [63:0]          hold_r;
  logic [63:0]          det_r;
  logic [63:0]          wval;
  logic [3:0][31:0]     col_r;
  logic                 mul_done, div_done;
  logic [63:0]          prod;
  logic [31:0]          quo;

  m4i_ram #(.WIDTH(MAT_WIDTH), .DEPTH(MAT_DEPTH)) u_mat (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col_sel),
    .wdata ({val_r3, val_r2, val_r1, val_r0}),
    .raddr (cmd.rd_op.addr[3:2]),
    .rdata (mat_rdata)
  );

  m4i_ram #(.WIDTH(64), .DEPTH(WORK_DEPTH)) u_work (
    .clk   (clk),
    .we    (cmd.wr_en && !cmd.wr_det),
    .waddr (cmd.wr_addr),
    .wdata (wval),
    .raddr (cmd.rd_op.addr),
    .rdata (work_rdata)
  );

  m4i_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (opa_r),
    .b     (opb_r),
    .done  (mul_done),
    .prod  (prod)
  );

  m4i_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (opa_r),
    .den   (det_r),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    rd_work_r <= cmd.rd_op.work;
    rd_row_r  <= cmd.rd_op.addr[1:0];
  end

  assign mat_elem = mat_rdata[{rd_row_r, 5'd0} +: 32];
  assign opnd_val = rd_work_r ? work_rdata : {{32{mat_elem[31]}}, mat_elem};

  always_comb begin
    case (cmd.mode)
      MODE_FIRST: acc_nxt = prod;
      MODE_ADD:   acc_nxt = sat_add(acc_r, prod);
      MODE_SUB:   acc_nxt = sat_sub(acc_r, prod);
      default:    acc_nxt = acc_r;
    endcase
  end

  assign wval = cmd.wr_merge ? sat_add(hold_r, acc_r) :
                cmd.wr_neg   ? sat_neg(acc_r) : acc_r;

  always_ff @(posedge clk) begin
    if (cmd.cap_a) opa_r <= opnd_val;
    if (cmd.cap_b) opb_r <= opnd_val;
    if (mul_done) begin
      acc_r <= acc_nxt;
      if (cmd.save_hold) hold_r <= acc_nxt;
    end
    if (cmd.wr_en && cmd.wr_det) det_r <= wval;
    if (div_done) col_r[cmd.row] <= quo;
    else if (cmd.zero_st) col_r[cmd.row] <= 32'd0;
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.singular = (det_r == 64'd0);
  assign rslt         = col_r;

endmodule
`default_nettype wire

// File: rtl/core/m4i_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_ctrl: controller of the 4x4 matrix inverse
// Steps the product sequence through the shared multiplier, then divides each
// adjugate element, or zeros it for a singular matrix, and hands out the four inverse columns.
// ----------------------------------------------------------------------------
module m4i_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              in_last,
  input  m4i_pkg::m4i_sts_t sts,
  input  logic              out_ready,
  output m4i_pkg::m4i_cmd_t cmd,
  output logic              in_ready,
  output logic              out_valid,
  output logic [1:0]        out_col
);
  import m4i_pkg::*;

  m4i_state_t state_r, state_nxt;
  logic [6:0] t_r, t_nxt;
  logic [3:0] e_r, e_nxt;
  term_t      term;
  logic       last_term;

  assign term      = term_of(t_r);
  assign last_term = (t_r == 7'(N_TERMS - 1));

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    e_nxt     = e_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_last) begin
          state_nxt = ST_RDA;
          t_nxt     = '0;
        end
      end
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_CAPB;
      ST_CAPB: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_MWAIT;
      ST_MWAIT: begin
        if (sts.mul_done) begin
          if (term.wr) begin
            state_nxt = ST_WR;
          end else begin
            state_nxt = ST_RDA;
            t_nxt     = t_r + 7'd1;
          end
        end
      end
      ST_WR: begin
        if (last_term) begin
          state_nxt = ST_DRD;
          e_nxt     = '0;
        end else begin
          state_nxt = ST_RDA;
          t_nxt     = t_r + 7'd1;
        end
      end
      ST_DRD:  state_nxt = ST_DCAP;
      ST_DCAP: state_nxt = ST_DSTART;
      ST_DSTART: begin
        if (sts.singular) begin
          if (e_r[1:0] == 2'd3) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_DRD;
            e_nxt     = e_r + 4'd1;
          end
        end else begin
          state_nxt = ST_DWAIT;
        end
      end
      ST_DWAIT: begin
        if (sts.div_done) begin
          if (e_r[1:0] == 2'd3) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_DRD;
            e_nxt     = e_r + 4'd1;
          end
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          if (e_r == 4'd15) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_DRD;
            e_nxt     = e_r + 4'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      t_r     <= '0;
      e_r     <= '0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
      e_r     <= e_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.rd_op     = term.opa;
    cmd.mode      = term.mode;
    cmd.save_hold = term.save_hold;
    cmd.wr_neg    = term.neg;
    cmd.wr_merge  = term.merge;
    cmd.wr_det    = term.to_det;
    cmd.wr_addr   = term.dst;
    cmd.row       = e_r[1:0];
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_RDA:    cmd.rd_op = term.opa;
      ST_RDB: begin
        cmd.rd_op = term.opb;
        cmd.cap_a = 1'b1;
      end
      ST_CAPB:   cmd.cap_b = 1'b1;
      ST_MUL:    cmd.mul_start = 1'b1;
      ST_MWAIT:  ;
      ST_WR:     cmd.wr_en = 1'b1;
      ST_DRD:    cmd.rd_op = work_op(WORK_AW'(6'(ADJ_BASE) + {2'b00, e_r}));
      ST_DCAP:   cmd.cap_a = 1'b1;
      ST_DSTART: begin
        cmd.div_start = !sts.singular;
        cmd.zero_st   = sts.singular;
      end
      ST_DWAIT:  ;
      ST_OUT:    out_valid = 1'b1;
      default:   ;
    endcase
  end

  assign out_col = e_r[3:2];

endmodule
`default_nettype wire

// File: rtl/core/matrix4x4_inverse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4x4_inverse: 4x4 matrix inverse, adjugate method, signed fixed point
// Columns load one per request; the request marked last starts inversion.
// ----------------------------------------------------------------------------
// After the last column the block is busy until the fourth result column is
// out and takes no load requests meanwhile; values are Q16.16 at the default
// FRAC_BITS of 16. That time is set by one shared 32x32 multiplier, which
// forms each of the 88 products of the cofactors, adjugate and determinant
// with operand fetch, plus one write for each of the 35 stored terms, and by a
// bit-serial divider with operand fetch for each of the 16 elements, which
// a singular matrix skips. Results come as four column requests, columns
// 0 to 3; a zero determinant flags singular and gives zeros.
// ----------------------------------------------------------------------------
module matrix4x4_inverse #(
  parameter int FRAC_BITS = m4i_pkg::FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  m4i_in_if.sink    in_ch,
  m4i_out_if.source out_ch
);
  import m4i_pkg::*;

  m4i_cmd_t         cmd;
  m4i_sts_t         sts;
  logic             in_ready;
  logic             in_fire;
  logic             out_valid;
  logic [1:0]       out_col;
  logic [3:0][31:0] rslt;

  assign in_fire = in_ch.valid && in_ready;

  m4i_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_last   (in_ch.is_last),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_col   (out_col)
  );

  m4i_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .col_sel (in_ch.col_sel),
    .val_r0  (in_ch.val_r0),
    .val_r1  (in_ch.val_r1),
    .val_r2  (in_ch.val_r2),
    .val_r3  (in_ch.val_r3),
    .cmd     (cmd),
    .sts     (sts),
    .rslt    (rslt)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.out_col    = out_col;
  assign out_ch.inv_r0     = signed'(rslt[0]);
  assign out_ch.inv_r1     = signed'(rslt[1]);
  assign out_ch.inv_r2     = signed'(rslt[2]);
  assign out_ch.inv_r3     = signed'(rslt[3]);
  assign out_ch.singular   = sts.singular;
  assign out_ch.end_of_run = (out_col == 2'd3);

endmodule
`default_nettype wire

// File: tb/sv/tb_m4i_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_m4i_if: testbench view of the matrix inverse channels
// The block's own channel interfaces are used directly; this file only
// supplies a helper type for the expected inverse columns.
// ----------------------------------------------------------------------------
package tb_m4i_pkg;
  typedef struct {
    logic [1:0]         col;
    logic signed [31:0] row [4];
    logic               singular;
    logic               end_of_run;
  } inv_col_t;
endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for matrix4x4_inverse
// Loads matrices column by column, predicts the four inverse columns with a
// bit-exact fixed-point adjugate computation and checks every result request.
// ----------------------------------------------------------------------------
module tb_top;
  import tb_m4i_pkg::*;

  localparam int FB = 16;
  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [1:0]         col;
    logic signed [31:0] v [4];
    logic               last;
  } load_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  bit   loading_done = 1'b0;
  bit   hold_off = 1'b0;
  bit   in_taken = 1'b0;

  load_t    load_q [$];
  inv_col_t inv_q [$];
  logic signed [31:0] store [16];
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_cnt = 0;

  m4i_in_if  in_ch();
  m4i_out_if out_ch();

  matrix4x4_inverse uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source));

  always #2 clk = ~clk;

  function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SMAX)) return SMAX;
    if (s < 65'(SMIN)) return SMIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(SMAX)) return SMAX;
    if (s < 65'(SMIN)) return SMIN;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] fmul(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [127:0] p;
    p = (128'(a) * 128'(b)) >>> FB;
    if (p > 128'(SMAX)) return SMAX;
    if (p < 128'(SMIN)) return SMIN;
    return p[63:0];
  endfunction

  function automatic logic signed [31:0] fdiv(logic signed [63:0] n, logic signed [63:0] d);
    logic signed [127:0] q;
    q = (128'(n) <<< FB) / 128'(d);
    if (q > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (q < -128'sh8000_0000) return 32'sh8000_0000;
    return q[31:0];
  endfunction

  function automatic logic signed [63:0] minor2(logic signed [63:0] a, logic signed [63:0] b,
                                                logic signed [63:0] c, logic signed [63:0] d);
    return ssub(fmul(a, b), fmul(c, d));
  endfunction

  task automatic predict_inverse();
    logic signed [63:0] m [4][4];
    logic signed [63:0] fac [6][4];
    logic signed [63:0] vec [4][4];
    logic signed [63:0] adj [4][4];
    logic signed [63:0] det;
    int ra, rb;
    inv_col_t e;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) m[c][r] = 64'(store[c*4+r]);
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin ra = 2; rb = 3; end
        1: begin ra = 1; rb = 3; end
        2: begin ra = 1; rb = 2; end
        3: begin ra = 0; rb = 3; end
        4: begin ra = 0; rb = 2; end
        default: begin ra = 0; rb = 1; end
      endcase
      fac[p][0] = minor2(m[2][ra], m[3][rb], m[3][ra], m[2][rb]);
      fac[p][1] = fac[p][0];
      fac[p][2] = minor2(m[1][ra], m[3][rb], m[3][ra], m[1][rb]);
      fac[p][3] = minor2(m[1][ra], m[2][rb], m[2][ra], m[1][rb]);
    end
    for (int i = 0; i < 4; i++) begin
      vec[i][0] = m[1][i];
      vec[i][1] = m[0][i];
      vec[i][2] = m[0][i];
      vec[i][3] = m[0][i];
    end
    for (int i = 0; i < 4; i++) begin
      adj[0][i] = sadd(ssub(fmul(vec[1][i], fac[0][i]), fmul(vec[2][i], fac[1][i])),
                       fmul(vec[3][i], fac[2][i]));
      adj[1][i] = sadd(ssub(fmul(vec[0][i], fac[0][i]), fmul(vec[2][i], fac[3][i])),
                       fmul(vec[3][i], fac[4][i]));
      adj[2][i] = sadd(ssub(fmul(vec[0][i], fac[1][i]), fmul(vec[1][i], fac[3][i])),
                       fmul(vec[3][i], fac[5][i]));
      adj[3][i] = sadd(ssub(fmul(vec[0][i], fac[2][i]), fmul(vec[1][i], fac[4][i])),
                       fmul(vec[2][i], fac[5][i]));
    end
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++)
        if ((c + i) % 2 == 1) adj[c][i] = (adj[c][i] == SMIN) ? SMAX : -adj[c][i];
    det = sadd(sadd(fmul(adj[0][0], m[0][0]), fmul(adj[1][0], m[0][1])),
               sadd(fmul(adj[2][0], m[0][2]), fmul(adj[3][0], m[0][3])));
    for (int c = 0; c < 4; c++) begin
      e.col = 2'(c);
      for (int i = 0; i < 4; i++) e.row[i] = (det == 0) ? 32'sd0 : fdiv(adj[c][i], det);
      e.singular = (det == 0);
      e.end_of_run = (c == 3);
      inv_q.push_back(e);
    end
  endtask

  task automatic report(string what, logic signed [63:0] got, logic signed [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic logic signed [31:0] rnd_val(int kind);
    case (kind)
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(0, 8'hFF) << 16)) - 32'sh0080_0000;
      2: return $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
      default: return $signed(32'($urandom_range(0, 131071))) - 32'sd65536;
    endcase
  endfunction

  task automatic add_matrix(int kind, bit scramble);
    load_t l;
    int order [4];
    for (int c = 0; c < 4; c++) order[c] = c;
    if (scramble) order.shuffle();
    for (int c = 0; c < 4; c++) begin
      l.col = 2'(order[c]);
      for (int r = 0; r < 4; r++) l.v[r] = rnd_val(kind);
      l.last = (c == 3);
      load_q.push_back(l);
    end
  endtask

  task automatic add_fixed(logic signed [31:0] a [16]);
    load_t l;
    for (int c = 0; c < 4; c++) begin
      l.col = 2'(c);
      for (int r = 0; r < 4; r++) l.v[r] = a[c*4+r];
      l.last = (c == 3);
      load_q.push_back(l);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
    end else begin
      if (in_ch.valid) void'(load_q.pop_front());
      if (gap_left > 0) gap_left--;
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
      if (load_q.size() > 0 && gap_left == 0 && !(hold_off && inv_q.size() > 0)) begin
        in_ch.valid   <= 1'b1;
        in_ch.col_sel <= load_q[0].col;
        in_ch.val_r0  <= load_q[0].v[0];
        in_ch.val_r1  <= load_q[0].v[1];
        in_ch.val_r2  <= load_q[0].v[2];
        in_ch.val_r3  <= load_q[0].v[3];
        in_ch.is_last <= load_q[0].last;
        if (burst_left > 0) burst_left--;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // prediction at acceptance
  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      store[in_ch.col_sel*4+0] = in_ch.val_r0;
      store[in_ch.col_sel*4+1] = in_ch.val_r1;
      store[in_ch.col_sel*4+2] = in_ch.val_r2;
      store[in_ch.col_sel*4+3] = in_ch.val_r3;
      if (in_ch.is_last) predict_inverse();
    end
  end

  // sink stall pattern
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1;
    out_ch.ready <= rst_n && ((stall_cnt % 64) < 32 || (stall_cnt % 7) != 3);
  end

  // monitor
  always @(posedge clk) begin
    inv_col_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (inv_q.size() == 0) begin
        report("unexpected result", 64'(out_ch.out_col), 0);
      end else begin
        e = inv_q.pop_front();
        if (out_ch.out_col !== e.col) report("out_col", 64'(out_ch.out_col), 64'(e.col));
        if (out_ch.inv_r0 !== e.row[0]) report("inv_r0", 64'(out_ch.inv_r0), 64'(e.row[0]));
        if (out_ch.inv_r1 !== e.row[1]) report("inv_r1", 64'(out_ch.inv_r1), 64'(e.row[1]));
        if (out_ch.inv_r2 !== e.row[2]) report("inv_r2", 64'(out_ch.inv_r2), 64'(e.row[2]));
        if (out_ch.inv_r3 !== e.row[3]) report("inv_r3", 64'(out_ch.inv_r3), 64'(e.row[3]));
        if (out_ch.singular !== e.singular)
          report("singular", 64'(out_ch.singular), 64'(e.singular));
        if (out_ch.end_of_run !== e.end_of_run)
          report("end_of_run", 64'(out_ch.end_of_run), 64'(e.end_of_run));
      end
    end
  end

  initial begin
    logic signed [31:0] a [16];
    load_t l;
    in_ch.valid = 1'b0;
    in_ch.col_sel = '0;
    in_ch.val_r0 = '0;
    in_ch.val_r1 = '0;
    in_ch.val_r2 = '0;
    in_ch.val_r3 = '0;
    in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;
    // identity
    for (int i = 0; i < 16; i++) a[i] = (i % 5 == 0) ? 32'sh0001_0000 : 32'sd0;
    add_fixed(a);
    // singular: all zero
    for (int i = 0; i < 16; i++) a[i] = 32'sd0;
    add_fixed(a);
    // extremes, saturating
    for (int i = 0; i < 16; i++) a[i] = (i % 5 == 0) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    add_fixed(a);
    for (int i = 0; i < 16; i++) a[i] = (i % 5 == 0) ? 32'sh7FFF_FFFF : 32'sh0000_0001;
    add_fixed(a);
    // partial reload: replace column 2 only, then a lone last on column 0
    l.col = 2'd2;
    l.v = '{32'sh0002_0000, -32'sh0001_8000, 32'sh0000_4000, 32'sh0003_0000};
    l.last = 1'b0;
    load_q.push_back(l);
    l.col = 2'd0;
    l.v = '{32'sh0000_8000, 32'sd0, -32'sh0001_0000, 32'sh0000_0001};
    l.last = 1'b1;
    load_q.push_back(l);
    while (load_q.size() < 416) begin
      add_matrix($urandom_range(0, 3), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) begin
        l.col = 2'($urandom_range(0, 3));
        for (int r = 0; r < 4; r++) l.v[r] = rnd_val($urandom_range(0, 3));
        l.last = 1'($urandom_range(0, 1));
        load_q.push_back(l);
      end
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (load_q.size() < 220);
    wait (inv_q.size() == 0);
    wait (inv_q.size() > 0);
    hold_off = 1'b1;
    wait (inv_q.size() == 0);
    hold_off = 1'b0;
    wait (load_q.size() == 0);
    wait (inv_q.size() == 0);
    repeat (3000) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
